/* rtl/ekvt_pkg.sv */
`timescale 1ns / 1ps
package ekvt_pkg;

  localparam logic [1:0] OP_SET    = 2'd0;
  localparam logic [1:0] OP_GET    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  localparam int KEY_W   = 64;
  localparam int VALUE_W = 64;
  localparam int NOW_W   = 32;
  localparam int TTL_W   = 16;
  localparam int EXP_W   = 33;
  localparam int LIVE_W  = 5;

  localparam logic [TTL_W-1:0] TTL_RESET = 16'd60;

  typedef struct packed {
    logic [1:0]         operation;
    logic [KEY_W-1:0]   lookup_key;
    logic [VALUE_W-1:0] write_value;
    logic [NOW_W-1:0]   now_seconds;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [VALUE_W-1:0] read_value;
    logic [LIVE_W-1:0]  live_count;
  } out_item_t;

endpackage

/* rtl/ekvt_in_if.sv */
`timescale 1ns / 1ps
interface ekvt_in_if;
  logic               valid;
  logic               ready;
  ekvt_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/ekvt_out_if.sv */
`timescale 1ns / 1ps
interface ekvt_out_if;
  logic                valid;
  logic                ready;
  ekvt_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/expiring_key_value_table_core.sv */
`timescale 1ns / 1ps
// Each item walks every entry held, from the first; full and unused items skip the walk.
// The table sits in one memory with one read and one write port, and one entry is
// compared, purged or moved down per cycle. The next item is accepted in the cycle its
// predecessor's result can first transfer; a waiting result stalls the input meanwhile.
// Synchronous reset empties the table and sets the time to live to 60; no clearing pass.
module expiring_key_value_table_core #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  ekvt_in_if.sink            in_chan,
  ekvt_out_if.source         out_chan,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int EW = ekvt_pkg::EXP_W;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic [EW-1:0]         expiry;
  } entry_t;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_TAIL, S_END, S_FINISH} state_t;

  entry_t mem [ENTRIES];
  entry_t rd_data_r;
  logic [IW-1:0] rd_addr;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  entry_t        mem_wdata;

  state_t                  state_r;
  logic [CW-1:0]           count_r;
  logic [CW-1:0]           rp_r;
  logic [CW-1:0]           wp_r;
  logic [1:0]              op_r;
  logic [KEY_BITS-1:0]     key_r;
  logic [VALUE_BITS-1:0]   val_r;
  logic [31:0]             now_r;
  logic [15:0]             ttl_r;
  logic [1:0]              res_status_r;
  logic [VALUE_BITS-1:0]   res_value_r;
  logic                    out_valid_r;
  ekvt_pkg::out_item_t     out_data_r;

  logic          expired;
  logic          key_hit;
  logic [EW-1:0] fresh_expiry;
  entry_t        fresh_entry;
  logic [CW-1:0] rp_inc;
  logic [CW-1:0] wp_inc;
  logic [CW-1:0] wp_hit_nxt;
  logic          last;

  assign expired      = rd_data_r.expiry < EW'(now_r);
  assign key_hit      = rd_data_r.key == key_r;
  assign fresh_expiry = EW'(now_r) + EW'(ttl_r);
  assign fresh_entry  = '{key: key_r, value: val_r, expiry: fresh_expiry};
  assign rp_inc       = rp_r + 1'b1;
  assign wp_inc       = wp_r + 1'b1;
  assign wp_hit_nxt   = (op_r == ekvt_pkg::OP_REMOVE) ? wp_r : wp_inc;
  assign last         = rp_inc == count_r;

  assign rd_addr   = (state_r == S_IDLE) ? '0 : rp_inc[IW-1:0];
  assign mem_waddr = wp_r[IW-1:0];

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = rd_data_r;
    unique case (state_r)
      S_SCAN: begin
        if (!expired) begin
          if (key_hit) begin
            if (op_r == ekvt_pkg::OP_SET) begin
              mem_we    = 1'b1;
              mem_wdata = fresh_entry;
            end else if (op_r == ekvt_pkg::OP_GET) begin
              mem_we = 1'b1;
            end
          end else begin
            mem_we = 1'b1;
          end
        end
      end
      S_TAIL: begin
        mem_we = 1'b1;
      end
      S_END: begin
        if (op_r == ekvt_pkg::OP_SET) begin
          mem_we    = 1'b1;
          mem_wdata = fresh_entry;
        end
      end
      S_IDLE, S_FINISH: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      ttl_r       <= ekvt_pkg::TTL_RESET;
    end else begin
      if (cfg_we) begin
        ttl_r <= cfg_wdata;
      end
      if (state_r == S_FINISH && (!out_valid_r || out_chan.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            op_r        <= in_chan.data.operation;
            key_r       <= in_chan.data.lookup_key[KEY_BITS-1:0];
            val_r       <= in_chan.data.write_value[VALUE_BITS-1:0];
            now_r       <= in_chan.data.now_seconds;
            rp_r        <= '0;
            wp_r        <= '0;
            res_value_r <= '0;
            if (in_chan.data.operation != ekvt_pkg::OP_SET &&
                in_chan.data.operation != ekvt_pkg::OP_GET &&
                in_chan.data.operation != ekvt_pkg::OP_REMOVE) begin
              res_status_r <= ekvt_pkg::ST_NOT_FOUND;
              state_r      <= S_FINISH;
            end else if (in_chan.data.operation == ekvt_pkg::OP_SET &&
                         count_r == CW'(ENTRIES)) begin
              res_status_r <= ekvt_pkg::ST_FULL;
              state_r      <= S_FINISH;
            end else if (count_r == '0) begin
              state_r <= S_END;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          rp_r <= rp_inc;
          if (expired) begin
            if (last) begin
              state_r <= S_END;
            end
          end else if (key_hit) begin
            res_status_r <= ekvt_pkg::ST_OK;
            if (op_r == ekvt_pkg::OP_GET) begin
              res_value_r <= rd_data_r.value;
            end
            wp_r <= wp_hit_nxt;
            if (last) begin
              count_r <= wp_hit_nxt;
              state_r <= S_FINISH;
            end else begin
              state_r <= S_TAIL;
            end
          end else begin
            wp_r <= wp_inc;
            if (last) begin
              state_r <= S_END;
            end
          end
        end
        S_TAIL: begin
          rp_r <= rp_inc;
          wp_r <= wp_inc;
          if (last) begin
            count_r <= wp_inc;
            state_r <= S_FINISH;
          end
        end
        S_END: begin
          if (op_r == ekvt_pkg::OP_SET) begin
            count_r      <= wp_inc;
            res_status_r <= ekvt_pkg::ST_OK;
          end else begin
            count_r      <= wp_r;
            res_status_r <= ekvt_pkg::ST_NOT_FOUND;
          end
          state_r <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid_r || out_chan.ready) begin
            out_data_r.status     <= res_status_r;
            out_data_r.read_value <= ekvt_pkg::VALUE_W'(res_value_r);
            out_data_r.live_count <= ekvt_pkg::LIVE_W'(count_r);
            state_r               <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign in_chan.ready  = state_r == S_IDLE;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;

  localparam int DEPTH = 16;
  localparam int KEY_POOL = 20;
  localparam int PHASE_ITEMS = 87;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int REPORT_LIMIT = 10;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    ekvt_pkg::in_item_t  item;
    bit                  pinned;
    ekvt_pkg::out_item_t result;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [ekvt_pkg::TTL_W-1:0] cfg_wdata;
  logic pin_valid;
  ekvt_pkg::out_item_t pin_result;

  ekvt_in_if  in_chan();
  ekvt_out_if out_chan();

  expiring_key_value_table_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  logic [ekvt_pkg::KEY_W-1:0]   shadow_key [DEPTH];
  logic [ekvt_pkg::VALUE_W-1:0] shadow_value [DEPTH];
  logic [ekvt_pkg::EXP_W-1:0]   shadow_expiry [DEPTH];
  int unsigned                  shadow_count;
  logic [ekvt_pkg::TTL_W-1:0]   shadow_ttl;

  ekvt_pkg::out_item_t          pending_results[$];
  row_t                         rows[$];
  logic [ekvt_pkg::KEY_W-1:0]   key_pool [KEY_POOL];
  logic [ekvt_pkg::NOW_W-1:0]   clock_base;
  int                           mismatches;
  int                           stall_cycles;
  int                           tx_idle_pct;
  int                           rx_idle_pct;
  int                           hold_left;
  bit                           hold_request;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void drop_entry(int unsigned pos);
    if (pos >= shadow_count) return;
    shadow_count--;
    for (int unsigned j = pos; j < shadow_count; j++) begin
      shadow_key[j]    = shadow_key[j + 1];
      shadow_value[j]  = shadow_value[j + 1];
      shadow_expiry[j] = shadow_expiry[j + 1];
    end
  endfunction

  // Expired entries met on the way are deleted and the walk retests the same slot.
  function automatic bit walk_table(logic [ekvt_pkg::KEY_W-1:0] key,
                                    logic [ekvt_pkg::NOW_W-1:0] now,
                                    output int unsigned slot);
    int unsigned i;
    i = 0;
    slot = 0;
    while (i < shadow_count) begin
      if (shadow_expiry[i] < ekvt_pkg::EXP_W'(now)) begin
        drop_entry(i);
      end else if (shadow_key[i] == key) begin
        slot = i;
        return 1'b1;
      end else begin
        i++;
      end
    end
    return 1'b0;
  endfunction

  function automatic ekvt_pkg::out_item_t apply_table_op(ekvt_pkg::in_item_t it);
    ekvt_pkg::out_item_t r;
    int unsigned slot;
    r.status = ekvt_pkg::ST_NOT_FOUND;
    r.read_value = '0;
    slot = 0;
    case (it.operation)
      ekvt_pkg::OP_SET: begin
        if (shadow_count >= DEPTH) begin
          r.status = ekvt_pkg::ST_FULL;
        end else begin
          if (!walk_table(it.lookup_key, it.now_seconds, slot)) begin
            slot = shadow_count;
            shadow_key[slot] = it.lookup_key;
            shadow_count++;
          end
          shadow_value[slot] = it.write_value;
          shadow_expiry[slot] = ekvt_pkg::EXP_W'(it.now_seconds) +
                                ekvt_pkg::EXP_W'(shadow_ttl);
          r.status = ekvt_pkg::ST_OK;
        end
      end
      ekvt_pkg::OP_GET: begin
        if (walk_table(it.lookup_key, it.now_seconds, slot)) begin
          r.read_value = shadow_value[slot];
          r.status = ekvt_pkg::ST_OK;
        end
      end
      ekvt_pkg::OP_REMOVE: begin
        if (walk_table(it.lookup_key, it.now_seconds, slot)) begin
          drop_entry(slot);
          r.status = ekvt_pkg::ST_OK;
        end
      end
      default: begin
      end
    endcase
    r.live_count = shadow_count[ekvt_pkg::LIVE_W-1:0];
    return r;
  endfunction

  function automatic void note_mismatch(string what, logic [ekvt_pkg::VALUE_W-1:0] want,
                                        logic [ekvt_pkg::VALUE_W-1:0] got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("tb: mismatch in %s at %0t: expected %h, got %h", what, $realtime, want, got);
    end
  endfunction

  always @(posedge clk) begin : monitor
    ekvt_pkg::out_item_t want;
    ekvt_pkg::out_item_t got;
    bit moved;
    moved = 1'b0;
    if (!rst_n) begin
      shadow_count = 0;
      shadow_ttl = ekvt_pkg::TTL_RESET;
      stall_cycles = 0;
    end else begin
      if (cfg_we) shadow_ttl = cfg_wdata;
      if (in_chan.valid && in_chan.ready) begin
        moved = 1'b1;
        want = apply_table_op(in_chan.data);
        if (pin_valid) want = pin_result;
        pending_results.push_back(want);
      end
      if (out_chan.valid && out_chan.ready) begin
        moved = 1'b1;
        got = out_chan.data;
        if (pending_results.size() == 0) begin
          note_mismatch("unexpected transfer", '0, got.read_value);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status) begin
            note_mismatch("status", ekvt_pkg::VALUE_W'(want.status),
                          ekvt_pkg::VALUE_W'(got.status));
          end
          if (got.read_value !== want.read_value) begin
            note_mismatch("read_value", want.read_value, got.read_value);
          end
          if (got.live_count !== want.live_count) begin
            note_mismatch("live_count", ekvt_pkg::VALUE_W'(want.live_count),
                          ekvt_pkg::VALUE_W'(got.live_count));
          end
        end
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_chan.ready <= 1'b0;
      hold_left--;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    wait (rst_n === 1'b1);
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  function automatic void add_row(logic [1:0] op, logic [ekvt_pkg::KEY_W-1:0] key,
                                  logic [ekvt_pkg::VALUE_W-1:0] value,
                                  logic [ekvt_pkg::NOW_W-1:0] now,
                                  logic [1:0] status,
                                  logic [ekvt_pkg::VALUE_W-1:0] read_value,
                                  logic [ekvt_pkg::LIVE_W-1:0] live);
    row_t r;
    r.item = '{operation: op, lookup_key: key, write_value: value, now_seconds: now};
    r.pinned = 1'b1;
    r.result = '{status: status, read_value: read_value, live_count: live};
    rows.push_back(r);
  endfunction

  function automatic ekvt_pkg::in_item_t random_item();
    ekvt_pkg::in_item_t it;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45) it.operation = ekvt_pkg::OP_SET;
    else if (pick < 77) it.operation = ekvt_pkg::OP_GET;
    else if (pick < 97) it.operation = ekvt_pkg::OP_REMOVE;
    else it.operation = OP_UNUSED;
    if ($urandom_range(99) < 94) it.lookup_key = key_pool[$urandom_range(KEY_POOL - 1)];
    else it.lookup_key = {$urandom, $urandom};
    it.write_value = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 2) clock_base = $urandom;
    else if (pick < 4) clock_base -= $urandom_range(50);
    else clock_base += $urandom_range(3);
    it.now_seconds = clock_base;
    return it;
  endfunction

  task automatic send_item(input ekvt_pkg::in_item_t it, input bit pinned,
                           input ekvt_pkg::out_item_t result);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data <= it;
    pin_valid <= pinned;
    pin_result <= result;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic drain_results();
    in_chan.valid <= 1'b0;
    pin_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * DEPTH) @(posedge clk);
  endtask

  task automatic start_phase(input logic [ekvt_pkg::TTL_W-1:0] ttl, input int tx_pct,
                             input int rx_pct);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= ttl;
    @(posedge clk);
    cfg_we <= 1'b0;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int k = 2; k < KEY_POOL; k++) key_pool[k] = {$urandom, $urandom};
    clock_base = ($urandom_range(3) == 0) ? 32'hFFFF_FF00 : $urandom;
  endtask

  initial begin
    ekvt_pkg::out_item_t none;
    logic [ekvt_pkg::TTL_W-1:0] ttl;
    none = '0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_chan.valid <= 1'b0;
    in_chan.data <= '0;
    pin_valid <= 1'b0;
    pin_result <= '0;
    mismatches = 0;
    hold_left = 0;
    hold_request = 1'b0;
    tx_idle_pct = 13;
    rx_idle_pct = 78;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(ekvt_pkg::OP_GET, '0, '0, '0, ekvt_pkg::ST_NOT_FOUND, '0, '0);
    add_row(ekvt_pkg::OP_REMOVE, '1, '0, '0, ekvt_pkg::ST_NOT_FOUND, '0, '0);
    add_row(OP_UNUSED, '1, '1, '1, ekvt_pkg::ST_NOT_FOUND, '0, '0);
    add_row(ekvt_pkg::OP_SET, '0, '1, '0, ekvt_pkg::ST_OK, '0, ekvt_pkg::LIVE_W'(1));
    add_row(ekvt_pkg::OP_GET, '0, '0, 32'd60, ekvt_pkg::ST_OK, '1, ekvt_pkg::LIVE_W'(1));
    add_row(ekvt_pkg::OP_SET, '1, '0, '1, ekvt_pkg::ST_OK, '0, ekvt_pkg::LIVE_W'(1));
    add_row(ekvt_pkg::OP_SET, '1, 64'd5, '1, ekvt_pkg::ST_OK, '0, ekvt_pkg::LIVE_W'(1));
    add_row(ekvt_pkg::OP_GET, '1, '0, '1, ekvt_pkg::ST_OK, 64'd5, ekvt_pkg::LIVE_W'(1));
    add_row(ekvt_pkg::OP_REMOVE, '1, '0, '1, ekvt_pkg::ST_OK, '0, '0);
    for (int k = 1; k <= DEPTH; k++) begin
      add_row(ekvt_pkg::OP_SET, ekvt_pkg::KEY_W'(k), ekvt_pkg::VALUE_W'(k), 32'd100,
              ekvt_pkg::ST_OK, '0, ekvt_pkg::LIVE_W'(k));
    end
    add_row(ekvt_pkg::OP_SET, 64'd1, 64'd7, 32'd100, ekvt_pkg::ST_FULL, '0,
            ekvt_pkg::LIVE_W'(DEPTH));
    add_row(ekvt_pkg::OP_SET, 64'd1000, 64'd7, 32'd300, ekvt_pkg::ST_FULL, '0,
            ekvt_pkg::LIVE_W'(DEPTH));
    add_row(ekvt_pkg::OP_GET, 64'd16, '0, 32'd161, ekvt_pkg::ST_NOT_FOUND, '0, '0);
    foreach (rows[i]) send_item(rows[i].item, rows[i].pinned, rows[i].result);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: ttl = '0;
        1: ttl = '1;
        2, 3: ttl = ekvt_pkg::TTL_W'($urandom_range(1, 30));
        4: ttl = 16'd17;
        default: ttl = ekvt_pkg::TTL_W'($urandom);
      endcase
      if (phase < 2) start_phase(ttl, 13, 78);
      else if (phase < 4) start_phase(ttl, 78, 13);
      else start_phase(ttl, 0, 0);
      if (phase == 2) hold_request = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 3 && n == PHASE_ITEMS / 2) drain_results();
        send_item(random_item(), 1'b0, none);
      end
    end

    drain_results();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
